>>> rtl/core/mzl_pkg.sv
// Shared constants, types and command structures for the multi-zone lamp exposure loop.
package mzl_pkg;

  localparam int REGION_COUNT = 4;
  localparam int LAMP_COUNT   = 8;
  localparam int TABLE_SIZE   = REGION_COUNT * LAMP_COUNT;

  localparam int REGION_IDX_W = $clog2(REGION_COUNT);
  localparam int LAMP_IDX_W   = $clog2(LAMP_COUNT);
  localparam int TABLE_IDX_W  = $clog2(TABLE_SIZE);
  localparam int SLOT_W       = 5;

  localparam int GRAY_W    = 16;
  localparam int LEVEL_W   = 15;
  localparam int WEIGHT_W  = 16;
  localparam int FRAMES_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Smoothed mean is Q16.8, error is signed Q16.8 with one extra bit of range.
  localparam int SMOOTH_W = 24;
  localparam int ERR_W    = 25;

  // Shared multiplier operands and product.
  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Weighted error sum, its split for the gain product, and the scaled product.
  localparam int SUM_W    = 43;
  localparam int SUM_LO_W = 21;
  localparam int P_W      = 60;
  localparam int ROUND_SHIFT = 34;
  localparam int DELTA_W  = P_W - ROUND_SHIFT;

  localparam logic [15:0] ALPHA_ONE = 16'd32768;
  localparam logic [LEVEL_W-1:0] INITIAL_LEVEL_DEF = 15'd12800;

  typedef enum logic [1:0] {
    OP_FRAME   = 2'd0,
    OP_WEIGHT  = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_GRAY  = 3'd0,
    CFG_DEAD_BAND    = 3'd1,
    CFG_LOOP_GAIN    = 3'd2,
    CFG_MIN_LEVEL    = 3'd3,
    CFG_MAX_LEVEL    = 3'd4,
    CFG_SMOOTHING    = 3'd5,
    CFG_FRAMES       = 3'd6,
    CFG_CHANGE_LIMIT = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    MUL_FILT = 2'd0,
    MUL_WGT  = 2'd1,
    MUL_GLO  = 2'd2,
    MUL_GHI  = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic [GRAY_W-1:0]   target_gray;
    logic [GRAY_W-1:0]   dead_band;
    logic [15:0]         loop_gain;
    logic [LEVEL_W-1:0]  min_level;
    logic [LEVEL_W-1:0]  max_level;
    logic [15:0]         smoothing_weight;
    logic [FRAMES_W-1:0] frames_for_stable;
    logic [LEVEL_W-1:0]  change_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    target_gray:       16'd32768,
    dead_band:         16'd1280,
    loop_gain:         16'd410,
    min_level:         15'd0,
    max_level:         15'd25600,
    smoothing_weight:  16'd9830,
    frames_for_stable: 8'd5,
    change_limit:      15'd128
  };

  typedef struct packed {
    logic [1:0]                         op;
    logic [REGION_COUNT-1:0][GRAY_W-1:0] region_mean;
    logic [SLOT_W-1:0]                  weight_slot;
    logic [WEIGHT_W-1:0]                weight_word;
  } in_item_t;

  typedef struct packed {
    logic [LAMP_COUNT-1:0][LEVEL_W-1:0] level;
    logic                               is_stable;
  } out_item_t;

  typedef struct packed {
    logic                    take_frame;
    logic                    wr_weight;
    logic                    restart;
    logic                    mul_en;
    mul_sel_t                mul_sel;
    logic [REGION_IDX_W-1:0] ridx;
    logic [LAMP_IDX_W-1:0]   lidx;
    logic                    calc_err;
    logic                    do_round;
    logic                    do_update;
    logic                    do_finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/core/mzl_in_if.sv
// Input channel interface: valid/ready handshake with the frame, weight and restart fields.
interface mzl_in_if;
  import mzl_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [GRAY_W-1:0]   region_mean_0;
  logic [GRAY_W-1:0]   region_mean_1;
  logic [GRAY_W-1:0]   region_mean_2;
  logic [GRAY_W-1:0]   region_mean_3;
  logic [SLOT_W-1:0]   weight_slot;
  logic signed [WEIGHT_W-1:0] weight_word;

  modport source (
    output valid, op, region_mean_0, region_mean_1, region_mean_2, region_mean_3,
           weight_slot, weight_word,
    input  ready
  );

  modport sink (
    input  valid, op, region_mean_0, region_mean_1, region_mean_2, region_mean_3,
           weight_slot, weight_word,
    output ready
  );
endinterface

>>> rtl/core/mzl_out_if.sv
// Result channel interface: valid/ready handshake with the eight lamp levels and stable flag.
interface mzl_out_if;
  import mzl_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_0;
  logic [LEVEL_W-1:0] level_1;
  logic [LEVEL_W-1:0] level_2;
  logic [LEVEL_W-1:0] level_3;
  logic [LEVEL_W-1:0] level_4;
  logic [LEVEL_W-1:0] level_5;
  logic [LEVEL_W-1:0] level_6;
  logic [LEVEL_W-1:0] level_7;
  logic               is_stable;

  modport source (
    output valid, level_0, level_1, level_2, level_3, level_4, level_5, level_6, level_7,
           is_stable,
    input  ready
  );

  modport sink (
    input  valid, level_0, level_1, level_2, level_3, level_4, level_5, level_6, level_7,
           is_stable,
    output ready
  );
endinterface

>>> rtl/core/mzl_cfg_regs.sv
// Configuration register bank with write-only access.
module mzl_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mzl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mzl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mzl_pkg::cfg_t                  cfg
);
  import mzl_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TARGET_GRAY:  cfg_r.target_gray       <= cfg_wdata;
        CFG_DEAD_BAND:    cfg_r.dead_band         <= cfg_wdata;
        CFG_LOOP_GAIN:    cfg_r.loop_gain         <= cfg_wdata;
        CFG_MIN_LEVEL:    cfg_r.min_level         <= cfg_wdata[LEVEL_W-1:0];
        CFG_MAX_LEVEL:    cfg_r.max_level         <= cfg_wdata[LEVEL_W-1:0];
        CFG_SMOOTHING:    cfg_r.smoothing_weight  <= cfg_wdata;
        CFG_FRAMES:       cfg_r.frames_for_stable <= cfg_wdata[FRAMES_W-1:0];
        CFG_CHANGE_LIMIT: cfg_r.change_limit      <= cfg_wdata[LEVEL_W-1:0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/mzl_ctrl.sv
// Sequencing state machine: steps the shared multiplier through filter, weights and gain.
module mzl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  output logic              in_ready,
  input  mzl_pkg::dp_stat_t stat,
  output mzl_pkg::dp_cmd_t  cmd
);
  import mzl_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_FILT   = 12'b0000_0000_0010,
    ST_FWAIT  = 12'b0000_0000_0100,
    ST_ERR    = 12'b0000_0000_1000,
    ST_WMUL   = 12'b0000_0001_0000,
    ST_WWAIT  = 12'b0000_0010_0000,
    ST_GLO    = 12'b0000_0100_0000,
    ST_GHI    = 12'b0000_1000_0000,
    ST_GWAIT  = 12'b0001_0000_0000,
    ST_ROUND  = 12'b0010_0000_0000,
    ST_UPD    = 12'b0100_0000_0000,
    ST_FINISH = 12'b1000_0000_0000
  } state_t;

  localparam logic [REGION_IDX_W-1:0] LAST_R = REGION_IDX_W'(REGION_COUNT - 1);
  localparam logic [LAMP_IDX_W-1:0]   LAST_L = LAMP_IDX_W'(LAMP_COUNT - 1);

  state_t                  state_r, state_nxt;
  logic [REGION_IDX_W-1:0] r_r, r_nxt;
  logic [LAMP_IDX_W-1:0]   l_r, l_nxt;

  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    l_nxt     = l_r;
    in_ready  = 1'b0;
    cmd            = '0;
    cmd.mul_sel    = MUL_FILT;
    cmd.ridx       = r_r;
    cmd.lidx       = l_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_op)
            OP_FRAME: begin
              cmd.take_frame = 1'b1;
              r_nxt          = '0;
              state_nxt      = ST_FILT;
            end
            OP_WEIGHT:  cmd.wr_weight = 1'b1;
            OP_RESTART: cmd.restart   = 1'b1;
            default: ;
          endcase
        end
      end
      ST_FILT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_FILT;
        if (r_r == LAST_R) begin
          state_nxt = ST_FWAIT;
        end else begin
          r_nxt = r_r + 1'b1;
        end
      end
      ST_FWAIT: state_nxt = ST_ERR;
      ST_ERR: begin
        cmd.calc_err = 1'b1;
        r_nxt        = '0;
        l_nxt        = '0;
        state_nxt    = ST_WMUL;
      end
      ST_WMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_WGT;
        if (r_r == LAST_R) begin
          r_nxt     = '0;
          state_nxt = ST_WWAIT;
        end else begin
          r_nxt = r_r + 1'b1;
        end
      end
      ST_WWAIT: state_nxt = ST_GLO;
      ST_GLO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GLO;
        state_nxt   = ST_GHI;
      end
      ST_GHI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GHI;
        state_nxt   = ST_GWAIT;
      end
      ST_GWAIT: state_nxt = ST_ROUND;
      ST_ROUND: begin
        cmd.do_round = 1'b1;
        state_nxt    = ST_UPD;
      end
      ST_UPD: begin
        cmd.do_update = 1'b1;
        if (l_r == LAST_L) begin
          state_nxt = ST_FINISH;
        end else begin
          l_nxt     = l_r + 1'b1;
          state_nxt = ST_WMUL;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.do_finish = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      r_r     <= '0;
      l_r     <= '0;
    end else begin
      state_r <= state_nxt;
      r_r     <= r_nxt;
      l_r     <= l_nxt;
    end
  end

endmodule

>>> rtl/core/mzl_datapath.sv
// Datapath: filter state, weight table, lamp levels, shared multiplier and output register.
module mzl_datapath #(
  parameter logic [mzl_pkg::LEVEL_W-1:0] INITIAL_LEVEL = mzl_pkg::INITIAL_LEVEL_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mzl_pkg::cfg_t      cfg,
  input  mzl_pkg::dp_cmd_t   cmd,
  output mzl_pkg::dp_stat_t  stat,
  input  mzl_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output mzl_pkg::out_item_t out_item
);
  import mzl_pkg::*;

  // Architectural state.
  logic [SMOOTH_W-1:0]      smooth_r [REGION_COUNT];
  logic                     filter_ready_r;
  logic [WEIGHT_W-1:0]      weight_r [TABLE_SIZE];
  logic [LEVEL_W-1:0]       level_r  [LAMP_COUNT];
  logic [FRAMES_W-1:0]      steady_cnt_r;

  // Working registers for one frame.
  logic [GRAY_W-1:0]        means_r  [REGION_COUNT];
  logic signed [ERR_W-1:0]  err_r    [REGION_COUNT];
  logic                     in_target_r;
  logic                     steady_chg_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     act_en_r;
  mul_sel_t                 act_sel_r;
  logic [REGION_IDX_W-1:0]  act_ridx_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [P_W-1:0]    p_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic                     out_valid_r;
  out_item_t                out_r;

  // Multiplier operand selection.
  logic [15:0]                alpha;
  logic [SMOOTH_W-1:0]        mean_ext;
  logic [ERR_W-1:0]           filt_diff;
  logic [TABLE_IDX_W-1:0]     widx;
  logic [WEIGHT_W-1:0]        wsel;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;

  assign alpha     = (cfg.smoothing_weight > ALPHA_ONE) ? ALPHA_ONE : cfg.smoothing_weight;
  assign mean_ext  = {means_r[cmd.ridx], 8'b0};
  assign filt_diff = {1'b0, mean_ext} - {1'b0, smooth_r[cmd.ridx]};
  // Region-major table: slot is region times lamp count plus lamp.
  assign widx      = {cmd.ridx, cmd.lidx};
  assign wsel      = weight_r[widx];

  always_comb begin
    case (cmd.mul_sel)
      MUL_FILT: begin
        mul_a = {filt_diff[ERR_W-1], filt_diff};
        mul_b = {2'b0, alpha};
      end
      MUL_WGT: begin
        mul_a = {err_r[cmd.ridx][ERR_W-1], err_r[cmd.ridx]};
        mul_b = {{(MUL_B_W-WEIGHT_W){wsel[WEIGHT_W-1]}}, wsel};
      end
      MUL_GLO: begin
        mul_a = {{(MUL_A_W-SUM_LO_W){1'b0}}, sum_r[SUM_LO_W-1:0]};
        mul_b = {2'b0, cfg.loop_gain};
      end
      default: begin
        mul_a = {{(MUL_A_W-(SUM_W-SUM_LO_W)){sum_r[SUM_W-1]}}, sum_r[SUM_W-1:SUM_LO_W]};
        mul_b = {2'b0, cfg.loop_gain};
      end
    endcase
  end

  // Filter result: (s << 15) + alpha * (m - s), rounded and shifted back to Q16.8.
  logic [PROD_W-1:0]   filt_total;
  logic [SMOOTH_W-1:0] filt_new;
  assign filt_total = {5'b0, smooth_r[act_ridx_r], 15'b0} + prod_r + PROD_W'(16384);
  assign filt_new   = filt_total[38:15];

  // Error and deadband per region.
  logic signed [ERR_W-1:0] err_raw [REGION_COUNT];
  logic [ERR_W-1:0]        err_mag [REGION_COUNT];
  logic [REGION_COUNT-1:0] err_in_band;

  always_comb begin
    for (int r = 0; r < REGION_COUNT; r++) begin
      err_raw[r]     = {1'b0, cfg.target_gray, 8'b0} - {1'b0, smooth_r[r]};
      err_mag[r]     = err_raw[r][ERR_W-1] ? ERR_W'(-err_raw[r]) : err_raw[r];
      err_in_band[r] = (err_mag[r] <= {1'b0, cfg.dead_band, 8'b0});
    end
  end

  // Round to nearest, ties away from zero: a negative value adds one less.
  logic signed [P_W-1:0] rnd_sum;
  assign rnd_sum = p_r + (P_W'(1) <<< (ROUND_SHIFT - 1)) - P_W'(p_r[P_W-1]);

  // Level update with clamp and steadiness check.
  logic [LEVEL_W-1:0]      old_level;
  logic signed [DELTA_W:0] v_raw;
  logic signed [DELTA_W:0] v_lo;
  logic signed [DELTA_W:0] v_hi;
  logic signed [DELTA_W:0] min_ext;
  logic signed [DELTA_W:0] max_ext;
  logic [LEVEL_W-1:0]      new_level;
  logic signed [LEVEL_W:0] chg;
  logic [LEVEL_W:0]        chg_mag;

  always_comb begin
    old_level = level_r[cmd.lidx];
    min_ext   = {{(DELTA_W+1-LEVEL_W){1'b0}}, cfg.min_level};
    max_ext   = {{(DELTA_W+1-LEVEL_W){1'b0}}, cfg.max_level};
    v_raw     = {{(DELTA_W+1-LEVEL_W){1'b0}}, old_level} + {delta_r[DELTA_W-1], delta_r};
    v_lo      = (v_raw < min_ext) ? min_ext : v_raw;
    v_hi      = (v_lo > max_ext) ? max_ext : v_lo;
    new_level = v_hi[LEVEL_W-1:0];
    chg       = {1'b0, new_level} - {1'b0, old_level};
    chg_mag   = chg[LEVEL_W] ? (LEVEL_W+1)'(-chg) : chg;
  end

  // Steady-frame counter, saturating.
  logic [FRAMES_W-1:0] cnt_nxt;
  always_comb begin
    if (in_target_r && steady_chg_r) begin
      cnt_nxt = (&steady_cnt_r) ? steady_cnt_r : steady_cnt_r + 1'b1;
    end else begin
      cnt_nxt = '0;
    end
  end

  // Control and architectural state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < REGION_COUNT; r++) smooth_r[r] <= '0;
      for (int i = 0; i < TABLE_SIZE; i++) weight_r[i] <= '0;
      for (int l = 0; l < LAMP_COUNT; l++) level_r[l] <= INITIAL_LEVEL;
      filter_ready_r <= 1'b0;
      steady_cnt_r   <= '0;
      act_en_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      act_en_r <= cmd.mul_en;

      if (cmd.restart) begin
        for (int r = 0; r < REGION_COUNT; r++) smooth_r[r] <= '0;
        filter_ready_r <= 1'b0;
        steady_cnt_r   <= '0;
      end

      if (cmd.wr_weight && (in_item.weight_slot < TABLE_SIZE)) begin
        weight_r[in_item.weight_slot[TABLE_IDX_W-1:0]] <= in_item.weight_word;
      end

      if (act_en_r && (act_sel_r == MUL_FILT)) begin
        smooth_r[act_ridx_r] <= filter_ready_r ? filt_new : {means_r[act_ridx_r], 8'b0};
      end

      if (cmd.calc_err) filter_ready_r <= 1'b1;

      if (cmd.do_update) level_r[cmd.lidx] <= new_level;

      if (cmd.do_finish) begin
        steady_cnt_r <= cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    prod_r     <= mul_a * mul_b;
    act_sel_r  <= cmd.mul_sel;
    act_ridx_r <= cmd.ridx;

    if (cmd.take_frame) begin
      for (int r = 0; r < REGION_COUNT; r++) means_r[r] <= in_item.region_mean[r];
      steady_chg_r <= 1'b1;
    end

    if (cmd.calc_err) begin
      for (int r = 0; r < REGION_COUNT; r++) err_r[r] <= err_in_band[r] ? '0 : err_raw[r];
      in_target_r <= &err_in_band;
    end

    if (act_en_r) begin
      case (act_sel_r)
        MUL_WGT:  sum_r <= (act_ridx_r == '0) ? prod_r[SUM_W-1:0]
                                              : sum_r + prod_r[SUM_W-1:0];
        MUL_GLO:  p_r   <= {{(P_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
        MUL_GHI:  p_r   <= p_r + {prod_r[P_W-SUM_LO_W-1:0], {SUM_LO_W{1'b0}}};
        default: ;
      endcase
    end

    if (cmd.do_round) delta_r <= rnd_sum[P_W-1:ROUND_SHIFT];

    if (cmd.do_update && (chg_mag > {1'b0, cfg.change_limit})) steady_chg_r <= 1'b0;

    if (cmd.do_finish) begin
      for (int l = 0; l < LAMP_COUNT; l++) out_r.level[l] <= level_r[l];
      out_r.is_stable <= (cnt_nxt >= cfg.frames_for_stable);
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

endmodule

>>> rtl/core/multi_zone_lamp_exposure_loop.sv
// Top level of the multi-zone infrared lamp exposure loop.
//
// The input channel carries one of three kinds of item per transfer: a frame
// of four region gray means, a write of one region-to-lamp weight, or a
// restart of the stability tracking. Only a frame produces a result; the
// result channel then carries the eight new lamp levels and the stable flag.
// Configuration registers are written through the plain cfg_ port and must
// only be changed while the block is idle.
//
// A weight write or restart is acted on as it is transferred. A frame runs
// through a single shared 26x18 multiplier: four filter products, then for
// each lamp four weight products and two gain products plus rounding and
// update, before its result is registered in the output register.
//
// The result sits in an output register, so a new item is accepted while a
// finished result still waits; if the receiver stalls, the next frame holds
// in its final step until the output register is free. Reset loads the
// register defaults, clears the weights and filter and sets every lamp to
// the initial level; the block is ready on the cycle after reset is released.
module multi_zone_lamp_exposure_loop #(
  parameter logic [mzl_pkg::LEVEL_W-1:0] INITIAL_LEVEL = mzl_pkg::INITIAL_LEVEL_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mzl_in_if.sink                         in_ch,
  mzl_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [mzl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mzl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mzl_pkg::*;

  cfg_t      cfg;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;
  logic      in_ready;

  // Gather the channel fields into the packed item seen by the datapath.
  assign in_item.op             = in_ch.op;
  assign in_item.region_mean[0] = in_ch.region_mean_0;
  assign in_item.region_mean[1] = in_ch.region_mean_1;
  assign in_item.region_mean[2] = in_ch.region_mean_2;
  assign in_item.region_mean[3] = in_ch.region_mean_3;
  assign in_item.weight_slot    = in_ch.weight_slot;
  assign in_item.weight_word    = in_ch.weight_word;
  assign in_ch.ready            = in_ready;

  mzl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mzl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mzl_datapath #(
    .INITIAL_LEVEL (INITIAL_LEVEL)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  // Spread the registered result over the channel's named fields.
  assign out_ch.valid     = out_valid;
  assign out_ch.level_0   = out_item.level[0];
  assign out_ch.level_1   = out_item.level[1];
  assign out_ch.level_2   = out_item.level[2];
  assign out_ch.level_3   = out_item.level[3];
  assign out_ch.level_4   = out_item.level[4];
  assign out_ch.level_5   = out_item.level[5];
  assign out_ch.level_6   = out_item.level[6];
  assign out_ch.level_7   = out_item.level[7];
  assign out_ch.is_stable = out_item.is_stable;

endmodule

>>> test/tb_multi_zone_lamp_exposure_loop.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multi-zone lamp exposure loop, with its own scoreboard.
module tb_multi_zone_lamp_exposure_loop;
  import mzl_pkg::*;

  // The run is cut off here. This leaves a wide margin over the slowest correct
  // run, drain pauses between settings included.
  localparam int CYCLE_LIMIT = 1000000;
  // This pause outlasts a frame from its transfer to its result, so nothing
  // can still be in flight when a register changes.
  localparam int DRAIN_CYCLES = 100;
  // Length of the long receiver hold-off that fills the block and stalls its input.
  localparam int STALL_CYCLES = 400;
  // The spare opcode, which the block must accept and ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Half of one output step, for rounding the gain product to the nearest level.
  localparam longint HALF_STEP = longint'(1) << (ROUND_SHIFT - 1);

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mzl_in_if in_ch ();
  mzl_out_if out_ch ();

  multi_zone_lamp_exposure_loop dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // The testbench's own copy of the loop state. It starts in the same state
  // that reset leaves the block in: register defaults, an empty filter, zero
  // weights and every lamp at the initial level.
  cfg_t                       loop_cfg = CFG_RESET;
  logic [SMOOTH_W-1:0]        smooth_mean [REGION_COUNT] = '{default: '0};
  bit                         filter_primed = 1'b0;
  logic signed [WEIGHT_W-1:0] weight_tab [TABLE_SIZE] = '{default: '0};
  longint                     lamp_level [LAMP_COUNT] = '{default: INITIAL_LEVEL_DEF};
  int                         steady_frames = 0;

  // Lamp results still owed by the block, oldest first.
  out_item_t pending_lamp_results [$];

  // Idle rates in percent for each side, and the receiver's hold-off counter.
  int send_idle_pct = 10;
  int recv_idle_pct = 20;
  int hold_cycles = 0;

  int mismatch_count = 0;
  int results_checked = 0;
  int frames_sent = 0;
  int weights_sent = 0;
  int restarts_sent = 0;
  int ignored_sent = 0;
  int configs_loaded = 0;
  int cycle_count = 0;

  // Works out what one accepted transfer does to the loop, and for a frame
  // queues the eight lamp levels and the stable flag that must come out.
  function automatic void advance_exposure_loop(input in_item_t it);
    longint unsigned alpha, scaled, acc;
    longint err [REGION_COUNT];
    longint band, mag, wsum, prod, delta, lvl, change;
    bit on_target, small_moves;
    out_item_t res;
    int r, l;
    on_target = 1'b1;
    small_moves = 1'b1;
    res = '0;
    case (it.op)
      OP_WEIGHT: begin
        if (it.weight_slot < TABLE_SIZE) weight_tab[it.weight_slot] = it.weight_word;
      end
      OP_RESTART: begin
        // Weights and lamp levels survive a restart; the filter and the count do not.
        steady_frames = 0;
        filter_primed = 1'b0;
        for (r = 0; r < REGION_COUNT; r++) smooth_mean[r] = '0;
      end
      OP_FRAME: begin
        // An alpha above one behaves as one; an alpha of zero freezes the filter.
        alpha = (loop_cfg.smoothing_weight > ALPHA_ONE) ? 64'd32768
                                                        : loop_cfg.smoothing_weight;
        for (r = 0; r < REGION_COUNT; r++) begin
          scaled = {it.region_mean[r], 8'h00};
          if (!filter_primed) begin
            smooth_mean[r] = scaled;
          end else begin
            acc = alpha * scaled + (64'd32768 - alpha) * smooth_mean[r];
            smooth_mean[r] = (acc + 64'd16384) >> 15;
          end
        end
        filter_primed = 1'b1;

        // Errors inside the dead band, its edge included, count as zero.
        band = longint'(loop_cfg.dead_band) << 8;
        for (r = 0; r < REGION_COUNT; r++) begin
          err[r] = (longint'(loop_cfg.target_gray) << 8) - longint'(smooth_mean[r]);
          mag = (err[r] < 0) ? -err[r] : err[r];
          if (mag <= band) begin
            err[r] = 0;
          end else begin
            on_target = 1'b0;
          end
        end

        for (l = 0; l < LAMP_COUNT; l++) begin
          wsum = 0;
          for (r = 0; r < REGION_COUNT; r++)
            wsum += longint'(weight_tab[r * LAMP_COUNT + l]) * err[r];
          // Round the gain product to the nearest level step, ties away from zero.
          prod = wsum * longint'(loop_cfg.loop_gain);
          mag = (prod < 0) ? -prod : prod;
          delta = (mag + HALF_STEP) >>> ROUND_SHIFT;
          if (prod < 0) delta = -delta;
          // The lower limit is applied first, so crossed limits end on max_level.
          lvl = lamp_level[l] + delta;
          if (lvl < longint'(loop_cfg.min_level)) lvl = loop_cfg.min_level;
          if (lvl > longint'(loop_cfg.max_level)) lvl = loop_cfg.max_level;
          change = lvl - lamp_level[l];
          if (change < 0) change = -change;
          if (change > longint'(loop_cfg.change_limit)) small_moves = 1'b0;
          lamp_level[l] = lvl;
          res.level[l] = lvl[LEVEL_W-1:0];
        end

        if (on_target && small_moves) begin
          if (steady_frames < 255) steady_frames++;
        end else begin
          steady_frames = 0;
        end
        res.is_stable = (steady_frames >= loop_cfg.frames_for_stable);
        pending_lamp_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // A frame of four means; the weight fields carry noise the block must ignore.
  function automatic in_item_t frame_item(input logic [GRAY_W-1:0] m0, m1, m2, m3);
    in_item_t it;
    it.op = OP_FRAME;
    it.region_mean[0] = m0;
    it.region_mean[1] = m1;
    it.region_mean[2] = m2;
    it.region_mean[3] = m3;
    it.weight_slot = $urandom_range(31);
    it.weight_word = $urandom_range(65535);
    return it;
  endfunction

  function automatic in_item_t weight_item(input logic [SLOT_W-1:0] slot,
                                           input logic [WEIGHT_W-1:0] word);
    in_item_t it;
    it.op = OP_WEIGHT;
    it.region_mean = {$urandom(), $urandom()};
    it.weight_slot = slot;
    it.weight_word = word;
    return it;
  endfunction

  // A restart or a spare opcode, with random content in every other field.
  function automatic in_item_t ctrl_item(input logic [1:0] op);
    in_item_t it;
    it.op = op;
    it.region_mean = {$urandom(), $urandom()};
    it.weight_slot = $urandom_range(31);
    it.weight_word = $urandom_range(65535);
    return it;
  endfunction

  // Region means are drawn mostly around the target, so that the loop spends
  // time both inside and outside the dead band and the stable flag can rise.
  function automatic logic [GRAY_W-1:0] pick_mean();
    int span, v;
    span = loop_cfg.dead_band;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = int'(loop_cfg.target_gray) + int'($urandom_range(2 * span)) - span;
      5, 6, 7: v = $urandom_range(65535);
      8: v = int'(loop_cfg.target_gray) + int'($urandom_range(4 * span + 64)) - 2 * span - 32;
      default: v = $urandom_range(1) ? 65535 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[GRAY_W-1:0];
  endfunction

  // Offers one item after a random gap and waits for its transfer. The valid
  // stays high afterwards, so back-to-back items keep it high between them.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.region_mean_0 <= it.region_mean[0];
    in_ch.region_mean_1 <= it.region_mean[1];
    in_ch.region_mean_2 <= it.region_mean[2];
    in_ch.region_mean_3 <= it.region_mean[3];
    in_ch.weight_slot <= it.weight_slot;
    in_ch.weight_word <= it.weight_word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    advance_exposure_loop(it);
    case (it.op)
      OP_FRAME: frames_sent++;
      OP_WEIGHT: weights_sent++;
      OP_RESTART: restarts_sent++;
      default: ignored_sent++;
    endcase
  endtask

  // Stops offering, waits for every owed result and then lets the block settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_lamp_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TARGET_GRAY:  loop_cfg.target_gray = val;
      CFG_DEAD_BAND:    loop_cfg.dead_band = val;
      CFG_LOOP_GAIN:    loop_cfg.loop_gain = val;
      CFG_MIN_LEVEL:    loop_cfg.min_level = val[LEVEL_W-1:0];
      CFG_MAX_LEVEL:    loop_cfg.max_level = val[LEVEL_W-1:0];
      CFG_SMOOTHING:    loop_cfg.smoothing_weight = val;
      CFG_FRAMES:       loop_cfg.frames_for_stable = val[FRAMES_W-1:0];
      CFG_CHANGE_LIMIT: loop_cfg.change_limit = val[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  // Writes every register. Only called while the block is idle.
  task automatic load_config(input cfg_t c);
    write_reg(CFG_TARGET_GRAY, c.target_gray);
    write_reg(CFG_DEAD_BAND, c.dead_band);
    write_reg(CFG_LOOP_GAIN, c.loop_gain);
    write_reg(CFG_MIN_LEVEL, {1'b0, c.min_level});
    write_reg(CFG_MAX_LEVEL, {1'b0, c.max_level});
    write_reg(CFG_SMOOTHING, c.smoothing_weight);
    write_reg(CFG_FRAMES, {8'h00, c.frames_for_stable});
    write_reg(CFG_CHANGE_LIMIT, {1'b0, c.change_limit});
    configs_loaded++;
  endtask

  // With the reset settings and zero weights the lamps hold still, so frames
  // at the target should walk the steady count up to the stable flag.
  task automatic test_settle_at_target();
    int n;
    for (n = 0; n < 6; n++) send_item(frame_item(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    // After a restart the filter loads the means directly. A mean right on
    // the dead band edge still counts as on target; one step beyond does not.
    send_item(ctrl_item(OP_RESTART));
    send_item(frame_item(16'h8500, 16'h7B00, 16'h8000, 16'h8500));
    send_item(ctrl_item(OP_RESTART));
    send_item(frame_item(16'h8501, 16'h8000, 16'h8000, 16'h7B00));
  endtask

  // Extreme weight words in the first and last slots, the spare opcode, and
  // frames at the ends of the gray range before and after a restart.
  task automatic test_ops_and_field_extremes();
    send_item(weight_item(5'd0, 16'h7FFF));
    send_item(weight_item(5'd31, 16'h8000));
    send_item(weight_item(5'd10, 16'h4000));
    send_item(weight_item(5'd21, 16'hC000));
    send_item(ctrl_item(OP_UNUSED));
    send_item(frame_item(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(frame_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(frame_item(16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA));
    send_item(ctrl_item(OP_RESTART));
    send_item(frame_item(16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555));
  endtask

  // Register settings at their corners, two frames under each.
  task automatic test_register_corners();
    cfg_t c;
    // Crossed limits under the largest gain: max_level must win. With no
    // frames required the stable flag is set whatever happens.
    c = CFG_RESET;
    c.min_level = 15'd25600;
    c.max_level = 15'd0;
    c.loop_gain = 16'hFFFF;
    c.frames_for_stable = 8'd0;
    drain_results();
    load_config(c);
    send_item(frame_item(16'h0000, 16'hFFFF, 16'h8000, 16'h1234));
    send_item(frame_item(16'h8000, 16'h4000, 16'hC000, 16'hFFFF));

    // An alpha of zero leaves the smoothed means where the last frame put them.
    c = CFG_RESET;
    c.smoothing_weight = 16'd0;
    c.loop_gain = 16'd2048;
    drain_results();
    load_config(c);
    send_item(frame_item(16'hFFFF, 16'h0000, 16'h1000, 16'hF000));
    send_item(frame_item(16'h0000, 16'hFFFF, 16'hF000, 16'h1000));

    // An alpha above one acts as one. The widest dead band, a target of 65280
    // and no tolerated change at all.
    c = CFG_RESET;
    c.smoothing_weight = 16'hFFFF;
    c.dead_band = 16'hFFFF;
    c.target_gray = 16'd65280;
    c.change_limit = 15'd0;
    drain_results();
    load_config(c);
    send_item(frame_item(16'h0000, 16'h8000, 16'hFFFF, 16'h7FFF));
    send_item(frame_item(16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00));

    // The low corners: zero target, no dead band, no gain, the smallest
    // alpha, the most frames required and the widest change limit.
    c = CFG_RESET;
    c.target_gray = 16'd0;
    c.dead_band = 16'd0;
    c.loop_gain = 16'd0;
    c.smoothing_weight = 16'd1;
    c.frames_for_stable = 8'd255;
    c.change_limit = 15'd25600;
    drain_results();
    load_config(c);
    send_item(frame_item(16'h0001, 16'hFFFF, 16'h0000, 16'h8000));
    send_item(frame_item(16'h0000, 16'h0000, 16'h0000, 16'h0000));
  endtask

  // The receiver holds off for a long stretch while frames keep coming, so
  // one result waits in the output register, the next frame parks in its
  // final step and the input side has to stall.
  task automatic test_output_stall();
    cfg_t c;
    int n;
    c = CFG_RESET;
    c.loop_gain = 16'd1024;
    drain_results();
    load_config(c);
    send_idle_pct = 0;
    hold_cycles = STALL_CYCLES;
    for (n = 0; n < 12; n++) send_item(frame_item(pick_mean(), pick_mean(), pick_mean(), pick_mean()));
    drain_results();
    send_idle_pct = 10;
  endtask

  // Three idling regimes, three random register settings under each and a
  // hundred counted transfers per setting: mostly frames, with weight writes,
  // restarts and the odd spare opcode mixed in.
  task automatic test_random_frames();
    cfg_t c;
    in_item_t it;
    int phase, seg, taken, pick, wv;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < 3; seg++) begin
        c.target_gray = $urandom_range(65280);
        c.dead_band = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(2560);
        c.loop_gain = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(4096);
        if ($urandom_range(9) == 0) begin
          c.min_level = $urandom_range(25600, 12801);
          c.max_level = $urandom_range(12799);
        end else begin
          c.min_level = $urandom_range(12800);
          c.max_level = $urandom_range(25600, 12800);
        end
        case ($urandom_range(9))
          0: c.smoothing_weight = 16'd0;
          1: c.smoothing_weight = $urandom_range(65535, 32769);
          default: c.smoothing_weight = $urandom_range(32768, 1);
        endcase
        case ($urandom_range(9))
          0: c.frames_for_stable = 8'd0;
          1: c.frames_for_stable = $urandom_range(255);
          default: c.frames_for_stable = $urandom_range(8, 1);
        endcase
        c.change_limit = ($urandom_range(3) == 0) ? $urandom_range(25600) : $urandom_range(512);
        drain_results();
        load_config(c);

        taken = 0;
        while (taken < 100) begin
          pick = $urandom_range(99);
          if (pick < 82) begin
            it = frame_item(pick_mean(), pick_mean(), pick_mean(), pick_mean());
          end else if (pick < 92) begin
            // Mostly modest weights so that the lamps do not just sit on a limit.
            wv = ($urandom_range(3) == 0) ? int'($urandom_range(65535))
                                          : int'($urandom_range(4096)) - 2048;
            it = weight_item($urandom_range(31), wv[WEIGHT_W-1:0]);
          end else if (pick < 97) begin
            it = ctrl_item(OP_RESTART);
          end else begin
            it = ctrl_item(OP_UNUSED);
          end
          send_item(it);
          if (it.op != OP_UNUSED) taken++;
        end
      end
    end
  endtask

  // Receiver and checker in one process. The handshake is judged on the
  // values from before the edge; ready for the next cycle is then chosen,
  // either from the hold-off counter or at the current idle rate.
  initial begin : result_receiver
    logic [LEVEL_W-1:0] seen [LAMP_COUNT];
    out_item_t want;
    int l;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen[0] = out_ch.level_0;
        seen[1] = out_ch.level_1;
        seen[2] = out_ch.level_2;
        seen[3] = out_ch.level_3;
        seen[4] = out_ch.level_4;
        seen[5] = out_ch.level_5;
        seen[6] = out_ch.level_6;
        seen[7] = out_ch.level_7;
        if (pending_lamp_results.size() == 0) begin
          $display("%0t: result transfer arrived with no frame outstanding", $time);
          mismatch_count++;
        end else begin
          want = pending_lamp_results.pop_front();
          results_checked++;
          for (l = 0; l < LAMP_COUNT; l++) begin
            if (seen[l] !== want.level[l]) begin
              $display("%0t: lamp %0d level expected %0d actual %0d",
                       $time, l, want.level[l], seen[l]);
              mismatch_count++;
            end
          end
          if (out_ch.is_stable !== want.is_stable) begin
            $display("%0t: stable flag expected %0b actual %0b",
                     $time, want.is_stable, out_ch.is_stable);
            mismatch_count++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_lamp_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_TARGET_GRAY;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_FRAME;
    in_ch.region_mean_0 <= '0;
    in_ch.region_mean_1 <= '0;
    in_ch.region_mean_2 <= '0;
    in_ch.region_mean_3 <= '0;
    in_ch.weight_slot <= '0;
    in_ch.weight_word <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_settle_at_target();
    test_ops_and_field_extremes();
    test_register_corners();
    test_output_stall();
    test_random_frames();
    drain_results();

    $display("Run covered %0d frames, %0d weight writes, %0d restarts and %0d ignored items",
             frames_sent, weights_sent, restarts_sent, ignored_sent);
    $display("under %0d register settings; %0d lamp results compared, %0d faults found.",
             configs_loaded, results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_lamp_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
